@@ sv/chip8_instruction_executor_core_macros.svh @@
// Assertion macros used by the checker file of the executor core.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C8X_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c8x check failed");

// Next-cycle implication, checked outside reset.
`define C8X_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c8x check failed");

`endif

@@ sv/c8x_pkg.sv @@
// Package with widths, codes and helper functions of the executor core.
package c8x_pkg;

    localparam int CMD_W  = 3;
    localparam int OP_W   = 16;
    localparam int KEY_W  = 16;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 12;
    localparam int PC_W   = 16;
    localparam int ERR_W  = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam int SCREEN_W_DEF    = 64;
    localparam int SCREEN_H_DEF    = 32;
    localparam int STACK_SLOTS_DEF = 16;
    localparam int MEM_BYTES_DEF   = 4096;
    localparam int KEY_COUNT       = 16;
    localparam int REG_COUNT       = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FONT_BASE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_START = 1'd1;

    localparam logic [CFG_DATA_W-1:0] FONT_BASE_RESET     = 12'd80;
    localparam logic [CFG_DATA_W-1:0] PROGRAM_START_RESET = 12'd512;

    localparam logic [CMD_W-1:0] CMD_EXEC  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDEF     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd3;

    localparam logic [OP_W-1:0] OP_CLS = 16'h00E0;
    localparam logic [OP_W-1:0] OP_RET = 16'h00EE;

    localparam logic [3:0] GRP_SYS   = 4'h0;
    localparam logic [3:0] GRP_JP    = 4'h1;
    localparam logic [3:0] GRP_CALL  = 4'h2;
    localparam logic [3:0] GRP_SE    = 4'h3;
    localparam logic [3:0] GRP_SNE   = 4'h4;
    localparam logic [3:0] GRP_SEXY  = 4'h5;
    localparam logic [3:0] GRP_LD    = 4'h6;
    localparam logic [3:0] GRP_ADD   = 4'h7;
    localparam logic [3:0] GRP_ALU   = 4'h8;
    localparam logic [3:0] GRP_SNEXY = 4'h9;
    localparam logic [3:0] GRP_LDI   = 4'hA;
    localparam logic [3:0] GRP_JPV0  = 4'hB;
    localparam logic [3:0] GRP_RND   = 4'hC;
    localparam logic [3:0] GRP_DRW   = 4'hD;
    localparam logic [3:0] GRP_SKP   = 4'hE;
    localparam logic [3:0] GRP_MISC  = 4'hF;

    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] FN_LD_DT    = 8'h07;
    localparam logic [7:0] FN_WAIT_KEY = 8'h0A;
    localparam logic [7:0] FN_SET_DT   = 8'h15;
    localparam logic [7:0] FN_SET_ST   = 8'h18;
    localparam logic [7:0] FN_ADD_I    = 8'h1E;
    localparam logic [7:0] FN_FONT     = 8'h29;
    localparam logic [7:0] FN_BCD      = 8'h33;
    localparam logic [7:0] FN_SAVE     = 8'h55;
    localparam logic [7:0] FN_LOAD     = 8'h65;

    localparam logic [3:0] FLAG_REG = 4'hF;

    // Hundreds, tens and ones of a byte, packed high to low.
    function automatic logic [23:0] bcd_digits(input logic [7:0] v);
        logic [7:0] h;
        logic [7:0] t;
        logic [7:0] r;
        h = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
        r = v - 8'(h * 8'd100);
        t = 8'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (r >= 8'(k * 10))
            begin
                t = 8'(k);
            end
        end
        return {h, t, 8'(r - 8'(t * 8'd10))};
    endfunction

endpackage

@@ sv/c8x_if.sv @@
// Handshake interfaces for the item, result and configuration channels.
interface c8x_item_if
    import c8x_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [OP_W-1:0]     opcode;
    logic [KEY_W-1:0]    key_state;
    logic [BYTE_W-1:0]   random_byte;
    logic [ADDR_W-1:0]   access_address;
    logic [BYTE_W-1:0]   write_byte;

    modport source (output valid, command, opcode, key_state, random_byte,
                    access_address, write_byte, input ready);
    modport sink (input valid, command, opcode, key_state, random_byte,
                  access_address, write_byte, output ready);
endinterface

interface c8x_result_if
    import c8x_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PC_W-1:0]   program_counter;
    logic [ERR_W-1:0]  error_code;
    logic              display_changed;
    logic              waiting_key;
    logic [BYTE_W-1:0] read_value;
    logic              sound_on;

    modport source (output valid, program_counter, error_code, display_changed,
                    waiting_key, read_value, sound_on, input ready);
    modport sink (input valid, program_counter, error_code, display_changed,
                  waiting_key, read_value, sound_on, output ready);
endinterface

interface c8x_cfg_if
    import c8x_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/chip8_instruction_executor_core.sv @@
// CHIP-8 executor: one word in, one word out. Register file, return stack, main memory
// and the display (one row per entry) sit in synchronous RAMs with registered reads and
// are worked on by a read-modify-write sequencer. A write or a tick acts as the word is
// taken, a pixel read first steps down the display rows to the addressed one, and each
// instruction reads Vx, Vy and V0 before it executes. Draw, BCD, save and load first
// reduce I modulo MEM_BYTES by repeated subtraction, a draw also its X and Y,
// then a draw reads and rewrites one display row per sprite row and save or load moves
// one register at a time. A clear sweeps max(SCREEN_H, 16) rows. After reset the same
// sweep clears the display and the registers; no word is taken during it. A finished
// result sits in an output register, so the next word can be taken while it waits.
module chip8_instruction_executor_core
    import c8x_pkg::*;
#(
    parameter int SCREEN_W    = SCREEN_W_DEF,
    parameter int SCREEN_H    = SCREEN_H_DEF,
    parameter int STACK_SLOTS = STACK_SLOTS_DEF,
    parameter int MEM_BYTES   = MEM_BYTES_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    c8x_item_if.sink     item,
    c8x_result_if.source result,
    c8x_cfg_if.sink      cfg
);

    localparam int MA_W   = $clog2(MEM_BYTES);
    localparam int ROW_W  = $clog2(SCREEN_H);
    localparam int COL_W  = $clog2(SCREEN_W);
    localparam int SP_W   = $clog2(STACK_SLOTS);
    localparam int SD_W   = $clog2(STACK_SLOTS + 1);
    localparam int PIXELS = SCREEN_W * SCREEN_H;
    localparam int CLR_N  = (SCREEN_H > REG_COUNT) ? SCREEN_H : REG_COUNT;
    localparam int CLR_W  = $clog2(CLR_N);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_VX   = 5'd2;
    localparam logic [4:0] S_VY   = 5'd3;
    localparam logic [4:0] S_V0   = 5'd4;
    localparam logic [4:0] S_EXEC = 5'd5;
    localparam logic [4:0] S_WB   = 5'd6;
    localparam logic [4:0] S_RET  = 5'd7;
    localparam logic [4:0] S_MOD  = 5'd8;
    localparam logic [4:0] S_DRD  = 5'd9;
    localparam logic [4:0] S_DRW  = 5'd10;
    localparam logic [4:0] S_DFIN = 5'd11;
    localparam logic [4:0] S_BCD  = 5'd12;
    localparam logic [4:0] S_SVR  = 5'd13;
    localparam logic [4:0] S_SVW  = 5'd14;
    localparam logic [4:0] S_LDR  = 5'd15;
    localparam logic [4:0] S_LDW  = 5'd16;
    localparam logic [4:0] S_RDM  = 5'd17;
    localparam logic [4:0] S_PIX  = 5'd18;
    localparam logic [4:0] S_PIXR = 5'd19;
    localparam logic [4:0] S_DONE = 5'd20;

    // control state
    logic [4:0]            state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PC_W-1:0]       pc_reg, pc_next;
    logic [PC_W-1:0]       i_reg, i_next;
    logic [SD_W-1:0]       depth_reg, depth_next;
    logic [7:0]            delay_reg, delay_next;
    logic [7:0]            sound_reg, sound_next;
    logic [CFG_DATA_W-1:0] font_reg, font_next;
    logic                  clr_item_reg, clr_item_next;
    logic [CLR_W-1:0]      clr_reg, clr_next;

    // payload and working registers
    logic [OP_W-1:0]   op_reg, op_next;
    logic [KEY_W-1:0]  keys_reg, keys_next;
    logic [7:0]        rnd_reg, rnd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]        vx_reg, vx_next;
    logic [7:0]        vy_reg, vy_next;
    logic [7:0]        v0_reg, v0_next;
    logic [7:0]        wb_reg, wb_next;
    logic [PC_W-1:0]   ia_reg, ia_next;
    logic [7:0]        px_reg, px_next;
    logic [7:0]        py_reg, py_next;
    logic [MA_W-1:0]   ptr_reg, ptr_next;
    logic [ROW_W-1:0]  crow_reg, crow_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              collide_reg, collide_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic              drawn_reg, drawn_next;
    logic              wait_reg, wait_next;
    logic [7:0]        rv_reg, rv_next;

    logic [PC_W-1:0]   out_pc_reg, out_pc_next;
    logic [ERR_W-1:0]  out_err_reg, out_err_next;
    logic              out_drawn_reg, out_drawn_next;
    logic              out_wait_reg, out_wait_next;
    logic [7:0]        out_rv_reg, out_rv_next;
    logic              out_snd_reg, out_snd_next;

    // RAM ports
    logic              rf_we;
    logic [3:0]        rf_waddr, rf_raddr;
    logic [7:0]        rf_wdata, rf_rdata;
    logic              fb_we;
    logic [ROW_W-1:0]  fb_waddr, fb_raddr;
    logic [SCREEN_W-1:0] fb_wdata, fb_rdata;
    logic              mm_we;
    logic [MA_W-1:0]   mm_waddr, mm_raddr;
    logic [7:0]        mm_wdata, mm_rdata;
    logic              st_we;
    logic [SP_W-1:0]   st_waddr, st_raddr;
    logic [PC_W-1:0]   st_wdata, st_rdata;

    // decode and helpers
    logic [3:0]          op_x, op_y, op_n;
    logic [7:0]          op_kk;
    logic [11:0]         op_nnn;
    logic [PC_W-1:0]     pc_plus2, pc_plus4;
    logic [MA_W-1:0]     ptr_inc;
    logic [ROW_W-1:0]    crow_inc;
    logic [SCREEN_W-1:0] sprite_mask;
    logic [3:0]          low_key;
    logic [23:0]         digits;
    logic [8:0]          alu_sum;
    logic                key_hit;
    logic                accept;

    assign op_x     = op_reg[11:8];
    assign op_y     = op_reg[7:4];
    assign op_n     = op_reg[3:0];
    assign op_kk    = op_reg[7:0];
    assign op_nnn   = op_reg[11:0];
    assign pc_plus2 = pc_reg + 16'd2;
    assign pc_plus4 = pc_reg + 16'd4;
    assign ptr_inc  = (ptr_reg == MA_W'(MEM_BYTES - 1)) ? '0 : ptr_reg + 1'b1;
    assign crow_inc = (crow_reg == ROW_W'(SCREEN_H - 1)) ? '0 : crow_reg + 1'b1;
    assign digits   = bcd_digits(vx_reg);
    assign alu_sum  = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign key_hit  = keys_reg[vx_reg[3:0]];
    assign accept   = item.valid && item.ready;

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid           = out_valid_reg;
    assign result.program_counter = out_pc_reg;
    assign result.error_code      = out_err_reg;
    assign result.display_changed = out_drawn_reg;
    assign result.waiting_key     = out_wait_reg;
    assign result.read_value      = out_rv_reg;
    assign result.sound_on        = out_snd_reg;

    // Place the sprite byte on the row at column px, wrapping at the right edge.
    always_comb
    begin
        logic [8:0] pos;
        sprite_mask = '0;
        for (int c = 0; c < 8; c++)
        begin
            pos = 9'(px_reg) + 9'(c);
            if (pos >= 9'(SCREEN_W))
            begin
                pos = pos - 9'(SCREEN_W);
            end
            if (mm_rdata[7 - c])
            begin
                sprite_mask[pos[COL_W-1:0]] = 1'b1;
            end
        end
    end

    always_comb
    begin
        low_key = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                low_key = 4'(k);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result.ready;
        pc_next        = pc_reg;
        i_next         = i_reg;
        depth_next     = depth_reg;
        delay_next     = delay_reg;
        sound_next     = sound_reg;
        font_next      = font_reg;
        clr_item_next  = clr_item_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        keys_next      = keys_reg;
        rnd_next       = rnd_reg;
        addr_next      = addr_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        v0_next        = v0_reg;
        wb_next        = wb_reg;
        ia_next        = ia_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ptr_next       = ptr_reg;
        crow_next      = crow_reg;
        cnt_next       = cnt_reg;
        collide_next   = collide_reg;
        err_next       = err_reg;
        drawn_next     = drawn_reg;
        wait_next      = wait_reg;
        rv_next        = rv_reg;
        out_pc_next    = out_pc_reg;
        out_err_next   = out_err_reg;
        out_drawn_next = out_drawn_reg;
        out_wait_next  = out_wait_reg;
        out_rv_next    = out_rv_reg;
        out_snd_next   = out_snd_reg;

        rf_we    = 1'b0;
        rf_waddr = op_x;
        rf_wdata = '0;
        rf_raddr = '0;
        fb_we    = 1'b0;
        fb_waddr = crow_reg;
        fb_wdata = '0;
        fb_raddr = crow_reg;
        mm_we    = 1'b0;
        mm_waddr = ptr_reg;
        mm_wdata = '0;
        mm_raddr = ptr_reg;
        st_we    = 1'b0;
        st_waddr = depth_reg[SP_W-1:0];
        st_wdata = pc_reg;
        st_raddr = SP_W'(depth_reg - 1'b1);

        unique case (state_reg)
            S_CLR:
            begin
                if (32'(clr_reg) < SCREEN_H)
                begin
                    fb_we    = 1'b1;
                    fb_waddr = ROW_W'(clr_reg);
                end
                if (!clr_item_reg && 32'(clr_reg) < REG_COUNT)
                begin
                    rf_we    = 1'b1;
                    rf_waddr = clr_reg[3:0];
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_N - 1))
                begin
                    clr_next = '0;
                    if (clr_item_reg)
                    begin
                        drawn_next = 1'b1;
                        pc_next    = pc_plus2;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                rf_raddr = item.opcode[11:8];
                mm_raddr = item.access_address[MA_W-1:0];
                if (accept)
                begin
                    op_next    = item.opcode;
                    keys_next  = item.key_state;
                    rnd_next   = item.random_byte;
                    addr_next  = item.access_address;
                    err_next   = ERR_OK;
                    drawn_next = 1'b0;
                    wait_next  = 1'b0;
                    rv_next    = '0;
                    state_next = S_DONE;
                    case (item.command)
                        CMD_EXEC: state_next = S_VX;
                        CMD_WRITE:
                        begin
                            if (32'(item.access_address) < MEM_BYTES)
                            begin
                                mm_we    = 1'b1;
                                mm_waddr = item.access_address[MA_W-1:0];
                                mm_wdata = item.write_byte;
                            end
                        end
                        CMD_READ:
                        begin
                            if (32'(item.access_address) < MEM_BYTES)
                            begin
                                state_next = S_RDM;
                            end
                        end
                        CMD_PIXEL:
                        begin
                            if (32'(item.access_address) < PIXELS)
                            begin
                                crow_next  = '0;
                                state_next = S_PIX;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (delay_reg != '0) delay_next = delay_reg - 1'b1;
                            if (sound_reg != '0) sound_next = sound_reg - 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_VX:
            begin
                vx_next    = rf_rdata;
                rf_raddr   = op_y;
                state_next = S_VY;
            end
            S_VY:
            begin
                vy_next    = rf_rdata;
                state_next = S_V0;
            end
            S_V0:
            begin
                v0_next    = rf_rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (op_reg[15:12])
                    GRP_SYS:
                    begin
                        if (op_reg == OP_CLS)
                        begin
                            clr_item_next = 1'b1;
                            clr_next      = '0;
                            state_next    = S_CLR;
                        end
                        else if (op_reg == OP_RET)
                        begin
                            if (depth_reg == '0)
                            begin
                                err_next = ERR_UNDERFLOW;
                            end
                            else
                            begin
                                state_next = S_RET;
                            end
                        end
                        else
                        begin
                            pc_next = pc_plus2;
                        end
                    end
                    GRP_JP: pc_next = PC_W'(op_nnn);
                    GRP_CALL:
                    begin
                        if (32'(depth_reg) >= STACK_SLOTS)
                        begin
                            err_next = ERR_OVERFLOW;
                        end
                        else
                        begin
                            st_we      = 1'b1;
                            depth_next = depth_reg + 1'b1;
                            pc_next    = PC_W'(op_nnn);
                        end
                    end
                    GRP_SE:    pc_next = (vx_reg == op_kk) ? pc_plus4 : pc_plus2;
                    GRP_SNE:   pc_next = (vx_reg != op_kk) ? pc_plus4 : pc_plus2;
                    GRP_SEXY:  pc_next = (vx_reg == vy_reg) ? pc_plus4 : pc_plus2;
                    GRP_SNEXY: pc_next = (vx_reg != vy_reg) ? pc_plus4 : pc_plus2;
                    GRP_LD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = op_kk;
                        pc_next  = pc_plus2;
                    end
                    GRP_ADD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = vx_reg + op_kk;
                        pc_next  = pc_plus2;
                    end
                    GRP_ALU:
                    begin
                        // Flagged ops write VF now and Vx next, so Vx wins when X is F.
                        rf_waddr = FLAG_REG;
                        unique case (op_n)
                            ALU_LD, ALU_OR, ALU_AND, ALU_XOR:
                            begin
                                rf_we    = 1'b1;
                                rf_waddr = op_x;
                                pc_next  = pc_plus2;
                                case (op_n)
                                    ALU_LD:  rf_wdata = vy_reg;
                                    ALU_OR:  rf_wdata = vx_reg | vy_reg;
                                    ALU_AND: rf_wdata = vx_reg & vy_reg;
                                    default: rf_wdata = vx_reg ^ vy_reg;
                                endcase
                            end
                            ALU_ADD:
                            begin
                                rf_we      = 1'b1;
                                rf_wdata   = {7'd0, alu_sum[8]};
                                wb_next    = alu_sum[7:0];
                                state_next = S_WB;
                            end
                            ALU_SUB:
                            begin
                                rf_we      = 1'b1;
                                rf_wdata   = {7'd0, vx_reg >= vy_reg};
                                wb_next    = vx_reg - vy_reg;
                                state_next = S_WB;
                            end
                            ALU_SHR:
                            begin
                                rf_we      = 1'b1;
                                rf_wdata   = {7'd0, vx_reg[0]};
                                wb_next    = {1'b0, vx_reg[7:1]};
                                state_next = S_WB;
                            end
                            ALU_SUBN:
                            begin
                                rf_we      = 1'b1;
                                rf_wdata   = {7'd0, vy_reg >= vx_reg};
                                wb_next    = vy_reg - vx_reg;
                                state_next = S_WB;
                            end
                            ALU_SHL:
                            begin
                                rf_we      = 1'b1;
                                rf_wdata   = {7'd0, vx_reg[7]};
                                wb_next    = {vx_reg[6:0], 1'b0};
                                state_next = S_WB;
                            end
                            default: err_next = ERR_UNDEF;
                        endcase
                    end
                    GRP_LDI:
                    begin
                        i_next  = PC_W'(op_nnn);
                        pc_next = pc_plus2;
                    end
                    GRP_JPV0: pc_next = PC_W'(v0_reg) + PC_W'(op_nnn);
                    GRP_RND:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = rnd_reg & op_kk;
                        pc_next  = pc_plus2;
                    end
                    GRP_DRW:
                    begin
                        ia_next      = i_reg;
                        px_next      = vx_reg;
                        py_next      = vy_reg;
                        cnt_next     = '0;
                        collide_next = 1'b0;
                        state_next   = S_MOD;
                    end
                    GRP_SKP:
                    begin
                        if (op_kk == KEY_SKP)
                        begin
                            pc_next = key_hit ? pc_plus4 : pc_plus2;
                        end
                        else if (op_kk == KEY_SKNP)
                        begin
                            pc_next = key_hit ? pc_plus2 : pc_plus4;
                        end
                        else
                        begin
                            err_next = ERR_UNDEF;
                        end
                    end
                    GRP_MISC:
                    begin
                        unique case (op_kk)
                            FN_LD_DT:
                            begin
                                rf_we    = 1'b1;
                                rf_wdata = delay_reg;
                                pc_next  = pc_plus2;
                            end
                            FN_WAIT_KEY:
                            begin
                                if (keys_reg == '0)
                                begin
                                    wait_next = 1'b1;
                                end
                                else
                                begin
                                    rf_we    = 1'b1;
                                    rf_wdata = {4'd0, low_key};
                                    pc_next  = pc_plus2;
                                end
                            end
                            FN_SET_DT:
                            begin
                                delay_next = vx_reg;
                                pc_next    = pc_plus2;
                            end
                            FN_SET_ST:
                            begin
                                sound_next = vx_reg;
                                pc_next    = pc_plus2;
                            end
                            FN_ADD_I:
                            begin
                                i_next  = i_reg + PC_W'(vx_reg);
                                pc_next = pc_plus2;
                            end
                            FN_FONT:
                            begin
                                i_next  = PC_W'({vx_reg, 2'b00}) + PC_W'(vx_reg)
                                          + PC_W'(font_reg);
                                pc_next = pc_plus2;
                            end
                            FN_BCD, FN_SAVE, FN_LOAD:
                            begin
                                ia_next    = i_reg;
                                px_next    = '0;
                                py_next    = '0;
                                cnt_next   = '0;
                                state_next = S_MOD;
                            end
                            default: err_next = ERR_UNDEF;
                        endcase
                    end
                    default: err_next = ERR_UNDEF;
                endcase
            end
            S_WB:
            begin
                rf_we      = 1'b1;
                rf_wdata   = wb_reg;
                pc_next    = pc_plus2;
                state_next = S_DONE;
            end
            S_RET:
            begin
                pc_next    = st_rdata + 16'd2;
                depth_next = depth_reg - 1'b1;
                state_next = S_DONE;
            end
            S_MOD:
            begin
                // One subtract per cycle on each coordinate and on I until all are in range.
                if (32'(ia_reg) >= MEM_BYTES) ia_next = ia_reg - PC_W'(MEM_BYTES);
                if (32'(px_reg) >= SCREEN_W)  px_next = px_reg - 8'(SCREEN_W);
                if (32'(py_reg) >= SCREEN_H)  py_next = py_reg - 8'(SCREEN_H);
                if (32'(ia_reg) < MEM_BYTES && 32'(px_reg) < SCREEN_W
                    && 32'(py_reg) < SCREEN_H)
                begin
                    ptr_next  = ia_reg[MA_W-1:0];
                    crow_next = py_reg[ROW_W-1:0];
                    if (op_reg[15:12] == GRP_DRW)
                    begin
                        state_next = S_DRD;
                    end
                    else if (op_kk == FN_BCD)
                    begin
                        state_next = S_BCD;
                    end
                    else if (op_kk == FN_SAVE)
                    begin
                        state_next = S_SVR;
                    end
                    else
                    begin
                        state_next = S_LDR;
                    end
                end
            end
            S_DRD:
            begin
                if (cnt_reg == op_n)
                begin
                    state_next = S_DFIN;
                end
                else
                begin
                    state_next = S_DRW;
                end
            end
            S_DRW:
            begin
                fb_we        = 1'b1;
                fb_wdata     = fb_rdata ^ sprite_mask;
                collide_next = collide_reg | (|(fb_rdata & sprite_mask));
                cnt_next     = cnt_reg + 1'b1;
                ptr_next     = ptr_inc;
                crow_next    = crow_inc;
                state_next   = S_DRD;
            end
            S_DFIN:
            begin
                rf_we      = 1'b1;
                rf_waddr   = FLAG_REG;
                rf_wdata   = {7'd0, collide_reg};
                drawn_next = 1'b1;
                pc_next    = pc_plus2;
                state_next = S_DONE;
            end
            S_BCD:
            begin
                mm_we = 1'b1;
                case (cnt_reg)
                    4'd0:    mm_wdata = digits[23:16];
                    4'd1:    mm_wdata = digits[15:8];
                    default: mm_wdata = digits[7:0];
                endcase
                ptr_next = ptr_inc;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd2)
                begin
                    pc_next    = pc_plus2;
                    state_next = S_DONE;
                end
            end
            S_SVR:
            begin
                rf_raddr   = cnt_reg;
                state_next = S_SVW;
            end
            S_SVW:
            begin
                mm_we    = 1'b1;
                mm_wdata = rf_rdata;
                ptr_next = ptr_inc;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == op_x)
                begin
                    pc_next    = pc_plus2;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SVR;
                end
            end
            S_LDR:
            begin
                state_next = S_LDW;
            end
            S_LDW:
            begin
                rf_we    = 1'b1;
                rf_waddr = cnt_reg;
                rf_wdata = mm_rdata;
                ptr_next = ptr_inc;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == op_x)
                begin
                    pc_next    = pc_plus2;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LDR;
                end
            end
            S_RDM:
            begin
                rv_next    = mm_rdata;
                state_next = S_DONE;
            end
            S_PIX:
            begin
                // Split the pixel index into row and column by repeated subtraction.
                if (32'(addr_reg) >= SCREEN_W)
                begin
                    addr_next = addr_reg - ADDR_W'(SCREEN_W);
                    crow_next = crow_reg + 1'b1;
                end
                else
                begin
                    state_next = S_PIXR;
                end
            end
            S_PIXR:
            begin
                rv_next    = {7'd0, fb_rdata[addr_reg[COL_W-1:0]]};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pc_next    = pc_reg;
                    out_err_next   = err_reg;
                    out_drawn_next = drawn_reg;
                    out_wait_next  = wait_reg;
                    out_rv_next    = rv_reg;
                    out_snd_next   = (sound_reg != '0);
                    clr_item_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg.valid)
        begin
            if (cfg.index == REG_FONT_BASE)
            begin
                font_next = cfg.data;
            end
            else
            begin
                pc_next = PC_W'(cfg.data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
            pc_reg        <= PC_W'(PROGRAM_START_RESET);
            i_reg         <= '0;
            depth_reg     <= '0;
            delay_reg     <= '0;
            sound_reg     <= '0;
            font_reg      <= FONT_BASE_RESET;
            clr_item_reg  <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            i_reg         <= i_next;
            depth_reg     <= depth_next;
            delay_reg     <= delay_next;
            sound_reg     <= sound_next;
            font_reg      <= font_next;
            clr_item_reg  <= clr_item_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        keys_reg      <= keys_next;
        rnd_reg       <= rnd_next;
        addr_reg      <= addr_next;
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        v0_reg        <= v0_next;
        wb_reg        <= wb_next;
        ia_reg        <= ia_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        ptr_reg       <= ptr_next;
        crow_reg      <= crow_next;
        cnt_reg       <= cnt_next;
        collide_reg   <= collide_next;
        err_reg       <= err_next;
        drawn_reg     <= drawn_next;
        wait_reg      <= wait_next;
        rv_reg        <= rv_next;
        out_pc_reg    <= out_pc_next;
        out_err_reg   <= out_err_next;
        out_drawn_reg <= out_drawn_next;
        out_wait_reg  <= out_wait_next;
        out_rv_reg    <= out_rv_next;
        out_snd_reg   <= out_snd_next;
    end

    c8x_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_regs (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    c8x_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_frame (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mm_we),
        .waddr (mm_waddr),
        .wdata (mm_wdata),
        .raddr (mm_raddr),
        .rdata (mm_rdata)
    );

    c8x_ram #(.WIDTH(PC_W), .DEPTH(STACK_SLOTS)) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

endmodule

@@ sv/c8x_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/c8x_checker.sv @@
// Port-level checker for the executor core, bound to the top level.
`include "chip8_instruction_executor_core_macros.svh"

module c8x_checker
    import c8x_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ERR_W-1:0]  error_code,
    input logic              display_changed,
    input logic              waiting_key,
    input logic [BYTE_W-1:0] read_value
);

    // hold a result word until taken
    `C8X_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // one word in flight: never ready right after taking a word
    `C8X_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // a failed instruction leaves no side results
    `C8X_ASSERT_IMP(a_err_clean, clk, rst_n, out_valid && error_code != ERR_OK,
        !display_changed && !waiting_key && read_value == '0)

    `C8X_ASSERT_IMP(a_wait_clean, clk, rst_n, out_valid && waiting_key,
        error_code == ERR_OK && !display_changed && read_value == '0)

endmodule

bind chip8_instruction_executor_core c8x_checker u_c8x_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (item.valid),
    .in_ready        (item.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .error_code      (result.error_code),
    .display_changed (result.display_changed),
    .waiting_key     (result.waiting_key),
    .read_value      (result.read_value)
);
